// ----- sv/oale_pkg.sv -----
// Package for the ordered array list engine: transaction types, operation
// and status codes, and the command/status structs between control and datapath.
// No dependencies.
package oale_pkg;

    // Default sizes of the list storage.
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed field widths of the transactions.
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int CNT_W    = 7;
    localparam int STATUS_W = 3;

    // Address width that covers the largest supported capacity.
    localparam int ADDR_W = 6;

    // Update rule: even indices add this constant, odd indices double.
    localparam int UPD_ADDEND = 5;

    // Operation codes.
    localparam logic [KIND_W-1:0] KIND_SEARCH  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REVERSE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UPDATE  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd4;

    // Write data source select for the list memory.
    localparam logic [1:0] WSEL_KEY = 2'd0;
    localparam logic [1:0] WSEL_RDA = 2'd1;
    localparam logic [1:0] WSEL_RDB = 2'd2;
    localparam logic [1:0] WSEL_UPD = 2'd3;

    // Request transaction.
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic [CNT_W-1:0]          position;
    } oale_req_t;

    // Response transaction.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    match_position;
        logic [CNT_W-1:0]    entry_count;
        logic                last;
    } oale_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_key;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [1:0]        wr_sel;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;
    } dp_sts_t;

endpackage

// ----- sv/oale_dp.sv -----
// Datapath of the ordered array list engine: list memory with two registered
// read ports and one write port, the search key and the write data selection.
// Depends on oale_pkg.
module oale_dp
    import oale_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic                      clk,
    input  dp_cmd_t                   cmd,
    input  logic signed [VALUE_W-1:0] value,
    output dp_sts_t                   sts
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] key_reg;
    logic [DATA_WIDTH-1:0] rda_reg;
    logic [DATA_WIDTH-1:0] rdb_reg;
    logic [DATA_WIDTH-1:0] wr_data;

    // Key register: the value is sign-extended or truncated to the word width.
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= DATA_WIDTH'(value);
        end
    end

    // List memory with registered reads; read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr[IDX_W-1:0]] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rda_reg <= mem[cmd.rd_addr_a[IDX_W-1:0]];
            rdb_reg <= mem[cmd.rd_addr_b[IDX_W-1:0]];
        end
    end

    // Write data selection, including the update rule chosen by index parity.
    always_comb
    begin
        case (cmd.wr_sel)
            WSEL_KEY: wr_data = key_reg;
            WSEL_RDA: wr_data = rda_reg;
            WSEL_RDB: wr_data = rdb_reg;
            WSEL_UPD:
            begin
                if (cmd.wr_addr[0])
                begin
                    wr_data = rda_reg << 1;
                end
                else
                begin
                    wr_data = rda_reg + DATA_WIDTH'(UPD_ADDEND);
                end
            end
            default: wr_data = rda_reg;
        endcase
    end

    // Search compare of the word just read against the key.
    assign sts.match = (rda_reg == key_reg);

endmodule

// ----- sv/oale_ctrl.sv -----
// Controller of the ordered array list engine: operation sequencer, entry
// count, search match tracking and the response output register.
// Depends on oale_pkg.
module oale_ctrl
    import oale_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  oale_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output oale_rsp_t rsp,
    output dp_cmd_t   dp_cmd,
    input  dp_sts_t   dp_sts
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SEARCH  = 3'd1;
    localparam logic [2:0] S_SHIFT   = 3'd2;
    localparam logic [2:0] S_INS_WR  = 3'd3;
    localparam logic [2:0] S_REV_WLO = 3'd4;
    localparam logic [2:0] S_REV_WHI = 3'd5;
    localparam logic [2:0] S_RESP    = 3'd6;

    // Walk modes of the shift state.
    localparam logic [1:0] MODE_INS = 2'd0;
    localparam logic [1:0] MODE_DEL = 2'd1;
    localparam logic [1:0] MODE_UPD = 2'd2;

    logic [2:0]          state_reg,       state_next;
    logic [CNT_W-1:0]    count_reg,       count_next;
    logic                rd_vld_reg,      rd_vld_next;
    logic                pend_vld_reg,    pend_vld_next;
    logic                rsp_vld_reg,     rsp_vld_next;
    logic [CNT_W-1:0]    idx_reg,         idx_next;
    logic [CNT_W-1:0]    left_reg,        left_next;
    logic [CNT_W-1:0]    rd_idx_reg,      rd_idx_next;
    logic [1:0]          mode_reg,        mode_next;
    logic [CNT_W-1:0]    pos_reg,         pos_next;
    logic [CNT_W-1:0]    lo_reg,          lo_next;
    logic [CNT_W-1:0]    hi_reg,          hi_next;
    logic [CNT_W-1:0]    pend_pos_reg,    pend_pos_next;
    logic [STATUS_W-1:0] resp_status_reg, resp_status_next;
    logic [CNT_W-1:0]    resp_pos_reg,    resp_pos_next;
    oale_rsp_t           rsp_reg,         rsp_next;

    logic      out_free;
    logic      emit;
    oale_rsp_t emit_data;
    logic      match;
    logic      hold;

    assign out_free  = !rsp_vld_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    // A search match is pending output when the read data is valid and equal.
    assign match = rd_vld_reg && dp_sts.match;
    assign hold  = match && pend_vld_reg && !out_free;

    // Sequencer next-state and command logic.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        rd_vld_next      = rd_vld_reg;
        pend_vld_next    = pend_vld_reg;
        idx_next         = idx_reg;
        left_next        = left_reg;
        rd_idx_next      = rd_idx_reg;
        mode_next        = mode_reg;
        pos_next         = pos_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        pend_pos_next    = pend_pos_reg;
        resp_status_next = resp_status_reg;
        resp_pos_next    = resp_pos_reg;
        dp_cmd           = '0;
        emit             = 1'b0;
        emit_data        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    dp_cmd.load_key  = 1'b1;
                    pos_next         = req.position;
                    resp_pos_next    = '0;
                    resp_status_next = ST_OK;
                    state_next       = S_RESP;
                    case (req.kind)
                        KIND_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                resp_status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                idx_next      = '0;
                                left_next     = count_reg;
                                rd_vld_next   = 1'b0;
                                pend_vld_next = 1'b0;
                                state_next    = S_SEARCH;
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (count_reg >= CAP_CNT)
                            begin
                                resp_status_next = ST_FULL;
                            end
                            else if ((req.position == '0) ||
                                     ({1'b0, req.position} > ({1'b0, count_reg} + 8'd1)))
                            begin
                                resp_status_next = ST_BADPOS;
                            end
                            else if (req.position == (count_reg + CNT_W'(1)))
                            begin
                                state_next = S_INS_WR;
                            end
                            else
                            begin
                                mode_next   = MODE_INS;
                                idx_next    = count_reg - CNT_W'(1);
                                left_next   = count_reg - req.position + CNT_W'(1);
                                rd_vld_next = 1'b0;
                                state_next  = S_SHIFT;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                resp_status_next = ST_EMPTY;
                            end
                            else if ((req.position == '0) || (req.position > count_reg))
                            begin
                                resp_status_next = ST_BADPOS;
                            end
                            else if (req.position == count_reg)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                mode_next   = MODE_DEL;
                                idx_next    = req.position;
                                left_next   = count_reg - req.position;
                                rd_vld_next = 1'b0;
                                state_next  = S_SHIFT;
                            end
                        end
                        KIND_REVERSE:
                        begin
                            if (count_reg >= CNT_W'(2))
                            begin
                                dp_cmd.rd_en     = 1'b1;
                                dp_cmd.rd_addr_a = '0;
                                dp_cmd.rd_addr_b = ADDR_W'(count_reg - CNT_W'(1));
                                lo_next          = '0;
                                hi_next          = count_reg - CNT_W'(1);
                                state_next       = S_REV_WLO;
                            end
                        end
                        KIND_UPDATE:
                        begin
                            if (count_reg != '0)
                            begin
                                mode_next   = MODE_UPD;
                                idx_next    = '0;
                                left_next   = count_reg;
                                rd_vld_next = 1'b0;
                                state_next  = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            resp_status_next = ST_OK;
                        end
                    endcase
                end
            end

            // Streaming walk: write back the word read last cycle, read the next.
            S_SHIFT:
            begin
                if (rd_vld_reg)
                begin
                    dp_cmd.wr_en = 1'b1;
                    case (mode_reg)
                        MODE_INS:
                        begin
                            dp_cmd.wr_addr = ADDR_W'(rd_idx_reg + CNT_W'(1));
                            dp_cmd.wr_sel  = WSEL_RDA;
                        end
                        MODE_DEL:
                        begin
                            dp_cmd.wr_addr = ADDR_W'(rd_idx_reg - CNT_W'(1));
                            dp_cmd.wr_sel  = WSEL_RDA;
                        end
                        default:
                        begin
                            dp_cmd.wr_addr = ADDR_W'(rd_idx_reg);
                            dp_cmd.wr_sel  = WSEL_UPD;
                        end
                    endcase
                end
                if (left_reg != '0)
                begin
                    dp_cmd.rd_en     = 1'b1;
                    dp_cmd.rd_addr_a = ADDR_W'(idx_reg);
                    rd_idx_next      = idx_reg;
                    left_next        = left_reg - CNT_W'(1);
                    rd_vld_next      = 1'b1;
                    if (mode_reg == MODE_INS)
                    begin
                        idx_next = idx_reg - CNT_W'(1);
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    rd_vld_next = 1'b0;
                    case (mode_reg)
                        MODE_INS:
                        begin
                            state_next = S_INS_WR;
                        end
                        MODE_DEL:
                        begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            // Insert: place the new word into the opened slot.
            S_INS_WR:
            begin
                dp_cmd.wr_en   = 1'b1;
                dp_cmd.wr_addr = ADDR_W'(pos_reg - CNT_W'(1));
                dp_cmd.wr_sel  = WSEL_KEY;
                count_next     = count_reg + CNT_W'(1);
                state_next     = S_RESP;
            end

            // Reverse: write the high word into the low slot.
            S_REV_WLO:
            begin
                dp_cmd.wr_en   = 1'b1;
                dp_cmd.wr_addr = ADDR_W'(lo_reg);
                dp_cmd.wr_sel  = WSEL_RDB;
                state_next     = S_REV_WHI;
            end

            // Reverse: write the low word into the high slot, fetch the next pair if one remains.
            S_REV_WHI:
            begin
                dp_cmd.wr_en   = 1'b1;
                dp_cmd.wr_addr = ADDR_W'(hi_reg);
                dp_cmd.wr_sel  = WSEL_RDA;
                lo_next        = lo_reg + CNT_W'(1);
                hi_next        = hi_reg - CNT_W'(1);
                if ((lo_reg + CNT_W'(2)) < hi_reg)
                begin
                    dp_cmd.rd_en     = 1'b1;
                    dp_cmd.rd_addr_a = ADDR_W'(lo_reg + CNT_W'(1));
                    dp_cmd.rd_addr_b = ADDR_W'(hi_reg - CNT_W'(1));
                    state_next       = S_REV_WLO;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            // Search: one match is held back so the final one can carry last.
            S_SEARCH:
            begin
                if (!hold)
                begin
                    if (match)
                    begin
                        if (pend_vld_reg)
                        begin
                            emit                     = 1'b1;
                            emit_data.status         = ST_OK;
                            emit_data.match_position = pend_pos_reg;
                            emit_data.entry_count    = count_reg;
                            emit_data.last           = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_pos_next = rd_idx_reg + CNT_W'(1);
                    end
                    if (left_reg != '0)
                    begin
                        dp_cmd.rd_en     = 1'b1;
                        dp_cmd.rd_addr_a = ADDR_W'(idx_reg);
                        rd_idx_next      = idx_reg;
                        idx_next         = idx_reg + CNT_W'(1);
                        left_next        = left_reg - CNT_W'(1);
                        rd_vld_next      = 1'b1;
                    end
                    else
                    begin
                        rd_vld_next = 1'b0;
                        state_next  = S_RESP;
                        if (match)
                        begin
                            resp_status_next = ST_OK;
                            resp_pos_next    = rd_idx_reg + CNT_W'(1);
                        end
                        else if (pend_vld_reg)
                        begin
                            resp_status_next = ST_OK;
                            resp_pos_next    = pend_pos_reg;
                        end
                        else
                        begin
                            resp_status_next = ST_NOTFOUND;
                            resp_pos_next    = '0;
                        end
                    end
                end
            end

            // Final transaction of the operation, marked last.
            S_RESP:
            begin
                if (out_free)
                begin
                    emit                     = 1'b1;
                    emit_data.status         = resp_status_reg;
                    emit_data.match_position = resp_pos_reg;
                    emit_data.entry_count    = count_reg;
                    emit_data.last           = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response output register.
    always_comb
    begin
        rsp_next     = rsp_reg;
        rsp_vld_next = rsp_vld_reg;
        if (emit)
        begin
            rsp_next     = emit_data;
            rsp_vld_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_vld_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            rsp_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_vld_reg   <= rd_vld_next;
            pend_vld_reg <= pend_vld_next;
            rsp_vld_reg  <= rsp_vld_next;
        end
    end

    // Walk indices and payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        left_reg        <= left_next;
        rd_idx_reg      <= rd_idx_next;
        mode_reg        <= mode_next;
        pos_reg         <= pos_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        pend_pos_reg    <= pend_pos_next;
        resp_status_reg <= resp_status_next;
        resp_pos_reg    <= resp_pos_next;
        rsp_reg         <= rsp_next;
    end

endmodule

// ----- sv/ordered_array_list_engine_unit.sv -----
// Top level of the ordered array list engine: controller and datapath.
// Depends on oale_pkg, oale_ctrl and oale_dp.
//
// The engine keeps an ordered list of up to CAPACITY signed words and runs one
// operation per request transaction: search, insert, delete, reverse or update.
// Operations run one at a time; req_stall is high from acceptance until the
// final response transaction is loaded into the output register. Every word
// moves through the single write port of the list memory. A search or an
// update walks every entry, an insert at position p below count + 1 or a
// delete at position p below count shifts the entries behind position p,
// and a reverse swaps pairs from both ends; any wait on rsp_stall delays
// the final response. An insert at the end of the list, deleting the last
// entry, rejected operations and operations on a list too short to walk
// finish without a walk. A search returns one transaction per match, in
// position order, with last set on the final one, or a single not-found
// transaction. The list needs no clearing after reset.
module ordered_array_list_engine_unit
    import oale_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  oale_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output oale_rsp_t rsp
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // Operation sequencer and response register.
    oale_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .dp_cmd    (dp_cmd),
        .dp_sts    (dp_sts)
    );

    // List memory and word arithmetic.
    oale_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk   (clk),
        .cmd   (dp_cmd),
        .value (req.value),
        .sts   (dp_sts)
    );

endmodule

// ----- dv/oale_list_checker.sv -----
// Checker for the ordered array list engine: watches both channels, predicts
// the response transactions of every accepted request and compares them.
// Depends on oale_pkg.
module oale_list_checker
    import oale_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  oale_req_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  oale_rsp_t rsp,
    output int        fail_count,
    output int        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP         = DEF_CAPACITY;
    localparam int REPORT_MAX  = 10;

    // Shadow copy of the list and its length.
    logic [VALUE_W-1:0] list_words [0:CAP-1];
    int                 list_len;

    // Responses still owed by the block, oldest first.
    oale_rsp_t          owed_rsps [$];
    int                 err_total = 0;

    // Applies one operation to the shadow list and queues its responses.
    task automatic apply_list_op(input oale_req_t op);
        oale_rsp_t          r;
        int                 hits;
        int                 seen;
        int                 pos;
        logic [VALUE_W-1:0] tmp;
        r = '0;
        r.last = 1'b1;
        pos = int'(op.position);
        case (op.kind)
            KIND_SEARCH:
            begin
                hits = 0;
                for (int i = 0; i < list_len; i++)
                begin
                    if (list_words[i] == op.value)
                        hits++;
                end
                if (hits == 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    // One transaction per match, in position order.
                    seen = 0;
                    for (int i = 0; i < list_len; i++)
                    begin
                        if (list_words[i] == op.value)
                        begin
                            seen++;
                            r.status = ST_OK;
                            r.match_position = CNT_W'(i + 1);
                            r.entry_count = CNT_W'(list_len);
                            r.last = (seen == hits);
                            owed_rsps.push_back(r);
                        end
                    end
                    return;
                end
            end
            KIND_INSERT:
            begin
                // The full test takes precedence over the position test.
                if (list_len >= CAP)
                    r.status = ST_FULL;
                else if (pos < 1 || pos > list_len + 1)
                    r.status = ST_BADPOS;
                else
                begin
                    for (int i = list_len; i >= pos; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[pos - 1] = op.value;
                    list_len++;
                    r.status = ST_OK;
                end
            end
            KIND_DELETE:
            begin
                // The empty test takes precedence over the position test.
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (pos < 1 || pos > list_len)
                    r.status = ST_BADPOS;
                else
                begin
                    for (int i = pos - 1; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                    r.status = ST_OK;
                end
            end
            KIND_REVERSE:
            begin
                for (int i = 0; i < list_len / 2; i++)
                begin
                    tmp = list_words[i];
                    list_words[i] = list_words[list_len - 1 - i];
                    list_words[list_len - 1 - i] = tmp;
                end
                r.status = ST_OK;
            end
            KIND_UPDATE:
            begin
                // Even indices add the constant, odd indices double; both wrap.
                for (int i = 0; i < list_len; i++)
                begin
                    if (i % 2 == 0)
                        list_words[i] = list_words[i] + VALUE_W'(UPD_ADDEND);
                    else
                        list_words[i] = list_words[i] << 1;
                end
                r.status = ST_OK;
            end
            default:
            begin
                // Spare codes leave the list alone.
                r.status = ST_OK;
            end
        endcase
        r.entry_count = CNT_W'(list_len);
        owed_rsps.push_back(r);
    endtask

    // Compares one accepted response with the oldest owed one.
    task automatic check_response(input oale_rsp_t got);
        oale_rsp_t want;
        if (owed_rsps.size() == 0)
        begin
            err_total++;
            if (err_total <= REPORT_MAX)
                $display("%0t: response with none owed: status=%0d match=%0d count=%0d last=%0b",
                         $realtime, got.status, got.match_position, got.entry_count,
                         got.last);
            return;
        end
        want = owed_rsps.pop_front();
        if (got.status !== want.status || got.match_position !== want.match_position ||
            got.entry_count !== want.entry_count || got.last !== want.last)
        begin
            err_total++;
            if (err_total <= REPORT_MAX)
            begin
                $display("%0t: mismatch: expected status=%0d match=%0d count=%0d last=%0b",
                         $realtime, want.status, want.match_position, want.entry_count,
                         want.last);
                $display("%0t:           got      status=%0d match=%0d count=%0d last=%0b",
                         $realtime, got.status, got.match_position, got.entry_count,
                         got.last);
            end
        end
    endtask

    // Sample both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_len = 0;
            owed_rsps.delete();
            fail_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                apply_list_op(req);
            if (rsp_valid && !rsp_stall)
                check_response(rsp);
            fail_count <= err_total;
            pending_count <= owed_rsps.size();
        end
    end

endmodule

// ----- dv/ordered_array_list_engine_unit_tb.sv -----
// Testbench top for the ordered array list engine: clock, reset, request and
// response stimulus with random idling, watchdog and verdict.
// Depends on oale_pkg, ordered_array_list_engine_unit and oale_list_checker.
module ordered_array_list_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import oale_pkg::*;

    localparam int CAPACITY      = DEF_CAPACITY;
    localparam int RANDOM_ITEMS  = 256;
    localparam int LONG_HOLD     = 300;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 150;

    // Kind codes that the block does not define.
    localparam int KIND_SPARE_FIRST = 5;
    localparam int KIND_SPARE_LAST  = 7;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    oale_req_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    oale_rsp_t rsp;
    int        fail_count;
    int        pending_count;

    int        list_fill = 0;
    int        burst_left = 0;
    int        hold_requests = 0;
    int        holds_served = 0;
    int        idle_cycles;
    int        random_sent = 0;

    ordered_array_list_engine_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    oale_list_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: ends the run when nothing is accepted for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Response side: phases of random stall density, plus long hold-offs on request.
    initial
    begin
        int pct;
        rsp_stall <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            case ($urandom_range(0, 3))
                0: pct = 0;
                1: pct = 20;
                2: pct = 50;
                default: pct = 75;
            endcase
            repeat ($urandom_range(10, 80))
            begin
                @(posedge clk);
                if (hold_requests != holds_served)
                begin
                    rsp_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge clk);
                    holds_served++;
                end
                rsp_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // Values that favor repeats and the extremes, so searches find matches.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -1;
            3: return 0;
            4, 5: return 17;
            6: return -42;
            default: return $urandom;
        endcase
    endfunction

    // Offers one request transaction, tracks the list length, then maybe idles.
    task automatic send_op(input logic [KIND_W-1:0] op_kind,
                           input logic signed [VALUE_W-1:0] op_value,
                           input logic [CNT_W-1:0] op_pos);
        int p;
        p = int'(op_pos);
        if (op_kind == KIND_INSERT && list_fill < CAPACITY && p >= 1 && p <= list_fill + 1)
            list_fill++;
        else if (op_kind == KIND_DELETE && list_fill > 0 && p >= 1 && p <= list_fill)
            list_fill--;
        req_valid <= 1'b1;
        req <= '{kind: op_kind, value: op_value, position: op_pos};
        do @(posedge clk); while (req_stall);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(0, 3) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    // Stops offering until every owed response has arrived.
    task automatic wait_drained();
        req_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    // One random operation; bias 0..2 shifts the mix from deletes to inserts.
    task automatic send_mixed_op(input int bias);
        int                          w;
        int                          ins_w;
        logic [KIND_W-1:0]           k;
        logic signed [VALUE_W-1:0]   v;
        logic [CNT_W-1:0]            p;
        ins_w = 20 + bias * 10;
        w = $urandom_range(0, 99);
        v = pick_value();
        p = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
        if (w < ins_w)
        begin
            k = KIND_INSERT;
            if ($urandom_range(0, 99) < 85)
                p = CNT_W'($urandom_range(1, list_fill + 1));
        end
        else if (w < 55)
        begin
            k = KIND_DELETE;
            if ($urandom_range(0, 99) < 85)
                p = CNT_W'($urandom_range(1, (list_fill > 0) ? list_fill : 1));
        end
        else if (w < 80)
        begin
            k = KIND_SEARCH;
            if ($urandom_range(0, 99) < 40)
                v = $urandom;
        end
        else if (w < 88)
            k = KIND_REVERSE;
        else if (w < 96)
            k = KIND_UPDATE;
        else
            k = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        send_op(k, v, p);
        random_sent++;
    endtask

    // Request stimulus and verdict.
    initial
    begin
        int                        scen;
        int                        iter;
        int                        bias;
        logic signed [VALUE_W-1:0] key_a;
        logic signed [VALUE_W-1:0] key_b;
        rst_n = 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list cases, bad positions, extremes, wraps, spare codes.
        send_op(KIND_SEARCH, 0, 0);
        send_op(KIND_DELETE, 0, 1);
        send_op(KIND_REVERSE, 0, 0);
        send_op(KIND_UPDATE, 0, 0);
        send_op(KIND_INSERT, 5, 0);
        send_op(KIND_INSERT, 5, 2);
        send_op(KIND_INSERT, 32'sh8000_0000, 1);
        send_op(KIND_INSERT, 32'sh7fff_ffff, 2);
        send_op(KIND_INSERT, -1, 1);
        send_op(KIND_INSERT, 0, CNT_W'(list_fill + 1));
        send_op(KIND_INSERT, -1, 127);
        send_op(KIND_INSERT, -1, 3);
        send_op(KIND_SEARCH, -1, 0);
        send_op(KIND_SEARCH, 32'sh7fff_ffff, 0);
        send_op(KIND_REVERSE, 0, 0);
        send_op(KIND_UPDATE, 0, 0);
        send_op(KIND_SEARCH, 4, 0);
        send_op(KIND_DELETE, 0, 0);
        send_op(KIND_DELETE, 0, CNT_W'(list_fill + 1));
        send_op(KIND_DELETE, 0, CNT_W'(list_fill));
        send_op(KIND_DELETE, 0, 1);
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
            send_op(KIND_W'(k), $urandom, CNT_W'($urandom));
        wait_drained();

        // Random scenarios until enough items have gone in.
        iter = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (iter == 1)
                scen = 0;
            else if (iter == 3)
                scen = 2;
            else
                scen = $urandom_range(0, 13);
            case (scen)
                0:
                begin
                    // Fill to capacity with two keys, search them, overflow, then reverse and update.
                    key_a = pick_value();
                    key_b = $urandom;
                    while (list_fill < CAPACITY)
                    begin
                        send_op(KIND_INSERT, ($urandom_range(0, 3) != 0) ? key_a : key_b,
                                CNT_W'($urandom_range(1, list_fill + 1)));
                        random_sent++;
                    end
                    send_op(KIND_SEARCH, key_a, 0);
                    send_op(KIND_SEARCH, key_b, 0);
                    send_op(KIND_INSERT, $urandom, CNT_W'($urandom_range(0, 127)));
                    send_op(KIND_REVERSE, 0, 0);
                    send_op(KIND_UPDATE, 0, 0);
                    random_sent += 5;
                end
                1:
                begin
                    // Drain to empty, then poke the empty list.
                    while (list_fill > 0)
                    begin
                        send_op(KIND_DELETE, $urandom, CNT_W'($urandom_range(1, list_fill)));
                        random_sent++;
                    end
                    send_op(KIND_DELETE, $urandom, CNT_W'($urandom_range(0, 127)));
                    send_op(KIND_SEARCH, pick_value(), 0);
                    random_sent += 2;
                end
                2:
                begin
                    // Long response hold-off while requests keep coming back to back.
                    hold_requests++;
                    burst_left = 12;
                    repeat (8) send_mixed_op(2);
                end
                3:
                    wait_drained();
                4:
                begin
                    // Noise over the whole field ranges.
                    repeat (6)
                    begin
                        send_op(KIND_W'($urandom_range(0, (1 << KIND_W) - 1)), $urandom,
                                CNT_W'($urandom_range(0, (1 << CNT_W) - 1)));
                        random_sent++;
                    end
                end
                default:
                begin
                    bias = $urandom_range(0, 2);
                    repeat ($urandom_range(5, 20)) send_mixed_op(bias);
                end
            endcase
            iter++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
